### design/y2r_pkg.sv
// Package for the YUV 4:2:2 to RGB888 converter.
// Payload structs, chroma stage struct, Q2.16 coefficients and clamp helper.
// No dependencies.
package y2r_pkg;

  localparam int CHR_W = 27;
  localparam int SUM_W = 28;

  localparam logic ORDER_YUYV = 1'b0;
  localparam logic ORDER_UYVY = 1'b1;

  localparam logic signed [CHR_W-1:0] COEF_RV = CHR_W'(91881);
  localparam logic signed [CHR_W-1:0] COEF_GU = CHR_W'(22553);
  localparam logic signed [CHR_W-1:0] COEF_GV = CHR_W'(46801);
  localparam logic signed [CHR_W-1:0] COEF_BU = CHR_W'(116129);

  typedef struct packed {
    logic [7:0] byte_a;
    logic [7:0] byte_b;
    logic [7:0] byte_c;
    logic [7:0] byte_d;
    logic       has_second;
  } y2r_in_t;

  typedef struct packed {
    logic [7:0] red_first;
    logic [7:0] green_first;
    logic [7:0] blue_first;
    logic [7:0] red_second;
    logic [7:0] green_second;
    logic [7:0] blue_second;
    logic       second_valid;
  } y2r_out_t;

  typedef struct packed {
    logic                    valid;
    logic                    has_second;
    logic [7:0]              y0;
    logic [7:0]              y1;
    logic signed [CHR_W-1:0] rv;
    logic signed [CHR_W-1:0] g;
    logic signed [CHR_W-1:0] bu;
  } y2r_chroma_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } y2r_rgb_t;

  function automatic logic [7:0] clamp_q16(logic signed [SUM_W-1:0] s);
    logic [7:0] res;
    if (s[SUM_W-1]) begin
      res = 8'd0;
    end else if (|s[SUM_W-2:24]) begin
      res = 8'd255;
    end else begin
      res = s[23:16];
    end
    return res;
  endfunction

endpackage

### design/yuv422_to_rgb888.sv
// Top level of the YUV 4:2:2 to RGB888 converter (BT.601 full range).
// Depends on y2r_pkg, y2r_chroma and y2r_lane.
//
// channel  | ports                         | transfer
// ---------+-------------------------------+----------------------------------
// input    | start, busy, in_data          | start && !busy at rising edge
// result   | out_valid, out_data           | out_valid for one cycle, no stall
// config   | cfg_valid, cfg_ready, cfg_data| cfg_valid && cfg_ready
//
// One macropixel per clock; busy stays low. Each result passes through the chroma
// product register, then the two lane adders/clamps feeding the output register.
// Synchronous reset clears byte_order and the valid bits. No backpressure on
// results.
module yuv422_to_rgb888
  import y2r_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  y2r_in_t  in_data,
  output logic     out_valid,
  output y2r_out_t out_data,
  input  logic     cfg_valid,
  output logic     cfg_ready,
  input  logic     cfg_data
);

  logic        byte_order_r;
  logic        acc;
  y2r_chroma_t chr;
  y2r_rgb_t    rgb0, rgb1;
  logic        out_valid_r;
  y2r_out_t    out_data_r, out_data_nxt;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign acc       = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_order_r <= ORDER_YUYV;
    end else if (cfg_valid && cfg_ready) begin
      byte_order_r <= cfg_data;
    end
  end

  y2r_chroma u_chroma (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (acc),
    .byte_order (byte_order_r),
    .in_data    (in_data),
    .chr        (chr)
  );

  y2r_lane u_lane0 (
    .luma (chr.y0),
    .rv   (chr.rv),
    .g    (chr.g),
    .bu   (chr.bu),
    .rgb  (rgb0)
  );

  y2r_lane u_lane1 (
    .luma (chr.y1),
    .rv   (chr.rv),
    .g    (chr.g),
    .bu   (chr.bu),
    .rgb  (rgb1)
  );

  // merge lanes; second pixel zeroed outside the row
  always_comb begin
    out_data_nxt.red_first    = rgb0.r;
    out_data_nxt.green_first  = rgb0.g;
    out_data_nxt.blue_first   = rgb0.b;
    out_data_nxt.red_second   = chr.has_second ? rgb1.r : 8'd0;
    out_data_nxt.green_second = chr.has_second ? rgb1.g : 8'd0;
    out_data_nxt.blue_second  = chr.has_second ? rgb1.b : 8'd0;
    out_data_nxt.second_valid = chr.has_second;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= chr.valid;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### design/y2r_chroma.sv
// Shared chroma stage: byte unpack by packing order and registered chroma products.
// Depends on y2r_pkg.
module y2r_chroma
  import y2r_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        acc,
  input  logic        byte_order,
  input  y2r_in_t     in_data,
  output y2r_chroma_t chr
);

  logic [7:0]              y0, y1, ub, vb;
  logic signed [8:0]       cu, cv;
  logic signed [CHR_W-1:0] cu_x, cv_x;
  y2r_chroma_t             chr_r, chr_nxt;

  always_comb begin
    unique case (byte_order)
      ORDER_YUYV: begin
        y0 = in_data.byte_a; ub = in_data.byte_b;
        y1 = in_data.byte_c; vb = in_data.byte_d;
      end
      ORDER_UYVY: begin
        ub = in_data.byte_a; y0 = in_data.byte_b;
        vb = in_data.byte_c; y1 = in_data.byte_d;
      end
      default: begin
        y0 = in_data.byte_a; ub = in_data.byte_b;
        y1 = in_data.byte_c; vb = in_data.byte_d;
      end
    endcase
    // byte minus 128
    cu   = $signed({~ub[7], ~ub[7], ub[6:0]});
    cv   = $signed({~vb[7], ~vb[7], vb[6:0]});
    cu_x = CHR_W'(cu);
    cv_x = CHR_W'(cv);
    chr_nxt.valid      = acc;
    chr_nxt.has_second = in_data.has_second;
    chr_nxt.y0         = y0;
    chr_nxt.y1         = y1;
    chr_nxt.rv         = cv_x * COEF_RV;
    chr_nxt.g          = -(cu_x * COEF_GU) - (cv_x * COEF_GV);
    chr_nxt.bu         = cu_x * COEF_BU;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chr_r.valid <= 1'b0;
    end else begin
      chr_r.valid <= chr_nxt.valid;
    end
    chr_r.has_second <= chr_nxt.has_second;
    chr_r.y0         <= chr_nxt.y0;
    chr_r.y1         <= chr_nxt.y1;
    chr_r.rv         <= chr_nxt.rv;
    chr_r.g          <= chr_nxt.g;
    chr_r.bu         <= chr_nxt.bu;
  end

  assign chr = chr_r;

endmodule

### design/y2r_lane.sv
// One pixel lane: adds scaled luma to the shared chroma terms and clamps to 0..255.
// Depends on y2r_pkg.
module y2r_lane
  import y2r_pkg::*;
(
  input  logic [7:0]              luma,
  input  logic signed [CHR_W-1:0] rv,
  input  logic signed [CHR_W-1:0] g,
  input  logic signed [CHR_W-1:0] bu,
  output y2r_rgb_t                rgb
);

  logic signed [SUM_W-1:0] base, sum_r, sum_g, sum_b;

  always_comb begin
    base  = $signed({{(SUM_W-24){1'b0}}, luma, 16'd0});
    sum_r = base + SUM_W'(rv);
    sum_g = base + SUM_W'(g);
    sum_b = base + SUM_W'(bu);
    rgb.r = clamp_q16(sum_r);
    rgb.g = clamp_q16(sum_g);
    rgb.b = clamp_q16(sum_b);
  end

endmodule

### design/y2r_checker.sv
// Port-level checker for yuv422_to_rgb888, attached by bind.
// Depends on y2r_pkg.
module y2r_checker
  import y2r_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     start,
  input logic     busy,
  input y2r_in_t  in_data,
  input logic     out_valid,
  input y2r_out_t out_data
);

  logic acc;
  assign acc = rst_n && start && !busy;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    acc |-> ##2 out_valid)
    else $error("input transfer without result two cycles later");

  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(acc, 2))
    else $error("result without matching input transfer");

  a_second_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.second_valid == $past(in_data.has_second, 2))
    else $error("second_valid does not follow has_second");

  a_second_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.second_valid |->
      out_data.red_second == 8'd0 && out_data.green_second == 8'd0 &&
      out_data.blue_second == 8'd0)
    else $error("second pixel not zero outside the row");

endmodule

bind yuv422_to_rgb888 y2r_checker u_y2r_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data)
);

### verif/testbench.sv
// Self-checking testbench for yuv422_to_rgb888: directed and random macropixels in both
// byte orders, predicted in Q16 fixed point and compared per field at the result strobe.
// Depends on y2r_pkg and the yuv422_to_rgb888 RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import y2r_pkg::*;

  localparam int CLK_HALF = 10;
  localparam int RESET_CYCLES = 8;
  localparam int RANDOM_ITEMS = 900;
  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 8;

  localparam longint Q16_ONE = 65536;
  localparam longint K_RV = 91881;
  localparam longint K_GU = 22553;
  localparam longint K_GV = 46801;
  localparam longint K_BU = 116129;
  localparam longint CHROMA_BIAS = 128;

  typedef enum logic [1:0] {ACT_PIXEL, ACT_ORDER, ACT_DRAIN} act_kind_t;

  typedef struct packed {
    act_kind_t kind;
    y2r_in_t   pixel;
    logic      order;
    logic [7:0] gap;
  } act_t;

  logic     clk;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  y2r_in_t  in_data = '0;
  logic     out_valid;
  y2r_out_t out_data;
  logic     cfg_valid = 1'b0;
  logic     cfg_ready;
  logic     cfg_data = 1'b0;

  act_t     plan[$];
  y2r_out_t rgb_expected[$];
  logic     byte_order_model = ORDER_YUYV;
  logic     plan_order = ORDER_YUYV;
  logic     armed = 1'b0;
  int       gap_left = 0;
  int       errors = 0;
  int       cycles = 0;

  yuv422_to_rgb888 dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  function automatic logic [7:0] sat_channel(longint sum);
    longint whole;
    if (sum < 0) begin
      return 8'd0;
    end
    whole = sum / Q16_ONE;
    if (whole > 255) begin
      return 8'd255;
    end
    return whole[7:0];
  endfunction

  function automatic y2r_out_t convert_pair(y2r_in_t px, logic order);
    longint y0, y1, cu, cv;
    y2r_out_t res;
    if (order == ORDER_YUYV) begin
      y0 = px.byte_a;
      cu = px.byte_b;
      y1 = px.byte_c;
      cv = px.byte_d;
    end else begin
      cu = px.byte_a;
      y0 = px.byte_b;
      cv = px.byte_c;
      y1 = px.byte_d;
    end
    cu = cu - CHROMA_BIAS;
    cv = cv - CHROMA_BIAS;
    res = '0;
    res.red_first   = sat_channel(y0 * Q16_ONE + K_RV * cv);
    res.green_first = sat_channel(y0 * Q16_ONE - K_GU * cu - K_GV * cv);
    res.blue_first  = sat_channel(y0 * Q16_ONE + K_BU * cu);
    if (px.has_second) begin
      res.red_second   = sat_channel(y1 * Q16_ONE + K_RV * cv);
      res.green_second = sat_channel(y1 * Q16_ONE - K_GU * cu - K_GV * cv);
      res.blue_second  = sat_channel(y1 * Q16_ONE + K_BU * cu);
      res.second_valid = 1'b1;
    end
    return res;
  endfunction

  // Mostly uniform, with extra weight on range edges and the chroma midpoint.
  function automatic logic [7:0] rand_byte();
    logic [7:0] edges [5];
    edges = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd255};
    if ($urandom_range(0, 4) == 0) begin
      return edges[$urandom_range(0, 4)];
    end
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 8'd0;
    end else if (r < 85) begin
      return 8'($urandom_range(1, 3));
    end else if (r < 97) begin
      return 8'($urandom_range(4, 12));
    end
    return 8'($urandom_range(20, 60));
  endfunction

  function automatic void push_pixel(logic [7:0] y0, logic [7:0] u, logic [7:0] y1,
                                     logic [7:0] v, logic second, logic [7:0] gap);
    act_t a;
    a = '0;
    a.kind = ACT_PIXEL;
    a.gap = gap;
    if (plan_order == ORDER_YUYV) begin
      a.pixel = '{byte_a: y0, byte_b: u, byte_c: y1, byte_d: v, has_second: second};
    end else begin
      a.pixel = '{byte_a: u, byte_b: y0, byte_c: v, byte_d: y1, has_second: second};
    end
    plan.push_back(a);
  endfunction

  function automatic void push_drain(logic [7:0] gap);
    act_t a;
    a = '0;
    a.kind = ACT_DRAIN;
    a.gap = gap;
    plan.push_back(a);
  endfunction

  // Register writes only go out once the pipeline has emptied.
  function automatic void push_order(logic order, logic [7:0] gap);
    act_t a;
    push_drain(8'd0);
    a = '0;
    a.kind = ACT_ORDER;
    a.order = order;
    a.gap = gap;
    plan.push_back(a);
    plan_order = order;
  endfunction

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : drive
    logic next_start, next_cfg;
    if (!rst_n) begin
      start <= 1'b0;
      cfg_valid <= 1'b0;
    end else begin
      next_start = start;
      next_cfg = cfg_valid;
      if (start && !busy) begin
        rgb_expected.push_back(convert_pair(in_data, byte_order_model));
        next_start = 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        byte_order_model = cfg_data;
        next_cfg = 1'b0;
      end
      if (!next_start && !next_cfg && plan.size() > 0) begin
        if (!armed) begin
          gap_left = plan[0].gap;
          armed = 1'b1;
        end
        if (gap_left > 0) begin
          gap_left--;
        end else begin
          unique case (plan[0].kind)
            ACT_PIXEL: begin
              in_data <= plan[0].pixel;
              next_start = 1'b1;
              plan.delete(0);
              armed = 1'b0;
            end
            ACT_ORDER: begin
              if (rgb_expected.size() == 0) begin
                cfg_data <= plan[0].order;
                next_cfg = 1'b1;
                plan.delete(0);
                armed = 1'b0;
              end
            end
            default: begin
              if (rgb_expected.size() == 0) begin
                plan.delete(0);
                armed = 1'b0;
              end
            end
          endcase
        end
      end
      start <= next_start;
      cfg_valid <= next_cfg;
    end
  end

  always @(posedge clk) begin : observe
    y2r_out_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (rgb_expected.size() == 0) begin
        $display("%0t: result with no transfer pending, expected none, actual %h",
                 $time, out_data);
        errors++;
      end else begin
        want = rgb_expected.pop_front();
        check_field("red_first", want.red_first, out_data.red_first);
        check_field("green_first", want.green_first, out_data.green_first);
        check_field("blue_first", want.blue_first, out_data.blue_first);
        check_field("red_second", want.red_second, out_data.red_second);
        check_field("green_second", want.green_second, out_data.green_second);
        check_field("blue_second", want.blue_second, out_data.blue_second);
        check_field("second_valid", 8'(want.second_valid), 8'(out_data.second_valid));
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: cycle limit reached", $time);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin : stimulus
    int ord, phase, sent, len, k;
    logic burst;
    for (ord = 0; ord < 2; ord++) begin
      push_order(ord[0], 8'd0);
      push_pixel(8'd0, 8'd128, 8'd0, 8'd128, 1'b1, 8'd0);
      push_pixel(8'd255, 8'd128, 8'd255, 8'd128, 1'b1, 8'd0);
      push_pixel(8'd0, 8'd0, 8'd255, 8'd0, 1'b1, 8'd1);
      push_pixel(8'd255, 8'd255, 8'd0, 8'd255, 1'b1, 8'd0);
      push_pixel(8'd255, 8'd0, 8'd255, 8'd255, 1'b1, 8'd2);
      push_pixel(8'd0, 8'd255, 8'd0, 8'd0, 1'b1, 8'd0);
      // second pixel outside the row
      push_pixel(8'd128, 8'd128, 8'd128, 8'd128, 1'b0, 8'd0);
      push_pixel(8'd200, 8'd17, 8'd90, 8'd240, 1'b0, 8'd3);
      push_pixel(8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 8'd0);
      push_pixel(8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 8'd0);
      push_pixel(8'd1, 8'd127, 8'd254, 8'd129, 1'b1, 8'd0);
    end

    sent = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      if (phase % 3 == 2) begin
        push_order(1'($urandom_range(0, 1)), pick_gap());
      end else begin
        push_order(phase[0], pick_gap());
      end
      burst = ($urandom_range(0, 3) == 0);
      len = $urandom_range(60, 200);
      for (k = 0; k < len && sent < RANDOM_ITEMS; k++) begin
        if ($urandom_range(0, 79) == 0) begin
          push_drain(pick_gap());
        end
        push_pixel(rand_byte(), rand_byte(), rand_byte(), rand_byte(),
                   $urandom_range(0, 3) != 0, burst ? 8'd0 : pick_gap());
        sent++;
      end
      phase++;
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    @(negedge clk);
    while (plan.size() > 0 || start || cfg_valid || rgb_expected.size() > 0) begin
      @(negedge clk);
    end
    repeat (TAIL_CYCLES) @(negedge clk);

    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
